### hw/rtl/afp_pkg.sv
package afp_pkg;

	// Width of every time value (signed microseconds).
	localparam int TIME_W = 48;
	// Time difference width: one guard bit, so any difference is exact.
	localparam int DIFF_W = TIME_W + 1;
	// Register value width.
	localparam int CFG_W = 24;
	// Working width of the frame delay (signed, holds up to 2^25 - 1).
	localparam int DLY_W = CFG_W + 2;
	// Result delay width.
	localparam int TGT_W = CFG_W + 1;

	localparam int APB_W = 32;
	localparam int ADDR_W = 5;
	localparam int IDX_W = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_MIN_SYNC_TH  = 3'd0,
		REG_MAX_SYNC_TH  = 3'd1,
		REG_FRAME_DUP_TH = 3'd2,
		REG_MAX_FRAME_DUR = 3'd3,
		REG_REFRESH_TIME = 3'd4,
		REG_DEFAULT_DUR  = 3'd5
	} reg_idx_t;

	localparam logic [CFG_W-1:0] RST_MIN_SYNC_TH   = 24'd40000;
	localparam logic [CFG_W-1:0] RST_MAX_SYNC_TH   = 24'd100000;
	localparam logic [CFG_W-1:0] RST_FRAME_DUP_TH  = 24'd100000;
	localparam logic [CFG_W-1:0] RST_MAX_FRAME_DUR = 24'd10000000;
	localparam logic [CFG_W-1:0] RST_REFRESH_TIME  = 24'd10000;
	localparam logic [CFG_W-1:0] RST_DEFAULT_DUR   = 24'd40000;

	typedef struct packed {
		logic [CFG_W-1:0] min_sync_th;
		logic [CFG_W-1:0] max_sync_th;
		logic [CFG_W-1:0] frame_dup_th;
		logic [CFG_W-1:0] max_frame_dur;
		logic [CFG_W-1:0] refresh_time;
		logic [CFG_W-1:0] default_dur;
	} cfg_t;

endpackage

### hw/rtl/av_sync_frame_pacer.sv
// Video frame pacer: for every frame transaction (pts, video clock, master
// clock, their valid flags and the current time, all signed microseconds) it
// returns one result transaction telling whether to show the frame now or how
// long to wait (at most refresh_time), plus the sync-adjusted frame delay.
// Throughput is one transaction per clock while the result side does not stall.
// The frame is captured in the input register when accepted, and the decision
// is registered in the result register when s1 advances; a stalled result
// lets one more frame wait in the input register before the input stalls.
// The pacing state (last shown pts, frame timer) is updated in the same cycle
// the result is registered, so the next frame already sees it. Registers sit
// on an APB port at byte addresses 4*i and should only be written while no
// transaction is in flight.
module av_sync_frame_pacer (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          frame_valid,
	output logic                          frame_stall,
	input  logic [afp_pkg::TIME_W-1:0]    frame_pts,
	input  logic                          frame_pts_valid,
	input  logic [afp_pkg::TIME_W-1:0]    video_clock,
	input  logic                          video_clock_valid,
	input  logic [afp_pkg::TIME_W-1:0]    master_clock,
	input  logic                          master_clock_valid,
	input  logic [afp_pkg::TIME_W-1:0]    now_time,

	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          show_frame,
	output logic [afp_pkg::CFG_W-1:0]     retry_wait,
	output logic [afp_pkg::TGT_W-1:0]     target_delay,

	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [afp_pkg::ADDR_W-1:0]    paddr,
	input  logic [afp_pkg::APB_W-1:0]     pwdata,
	output logic [afp_pkg::APB_W-1:0]     prdata,
	output logic                          pready
);
	import afp_pkg::*;

	cfg_t cfg;

	afp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ---------------------------------------------------------------
	// Handshake: input register (s1) feeds the result register. s1 moves
	// on whenever the result register is empty or being drained.
	// ---------------------------------------------------------------
	logic valid_s1;
	logic result_valid_q;
	logic accept;
	logic advance;
	logic out_free;

	assign out_free    = ~result_valid_q | ~result_stall;
	assign advance     = valid_s1 & out_free;
	assign frame_stall = valid_s1 & ~out_free;
	assign accept      = frame_valid & ~frame_stall;

	// ---------------------------------------------------------------
	// Input register
	// ---------------------------------------------------------------
	logic [TIME_W-1:0] pts_s1;
	logic              pts_ok_s1;
	logic [TIME_W-1:0] vclk_s1;
	logic              vclk_ok_s1;
	logic [TIME_W-1:0] mclk_s1;
	logic              mclk_ok_s1;
	logic [TIME_W-1:0] now_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pts_s1     <= frame_pts;
			pts_ok_s1  <= frame_pts_valid;
			vclk_s1    <= video_clock;
			vclk_ok_s1 <= video_clock_valid;
			mclk_s1    <= master_clock;
			mclk_ok_s1 <= master_clock_valid;
			now_s1     <= now_time;
		end
	end

	// ---------------------------------------------------------------
	// Video-vs-master drift, exact in DIFF_W.
	// ---------------------------------------------------------------
	logic signed [DIFF_W-1:0] drift_full;
	logic signed [DIFF_W-1:0] max_dur_ext;
	logic                     master_pos;
	logic                     sync_ok;
	logic signed [DLY_W-1:0]  drift;

	assign drift_full  = $signed({vclk_s1[TIME_W-1], vclk_s1})
	                   - $signed({mclk_s1[TIME_W-1], mclk_s1});
	assign max_dur_ext = $signed({{(DIFF_W-CFG_W){1'b0}}, cfg.max_frame_dur});
	assign master_pos  = ~mclk_s1[TIME_W-1] & (|mclk_s1);
	// Sync only with both clocks valid, master positive and drift plausible.
	assign sync_ok = mclk_ok_s1 & vclk_ok_s1 & master_pos
	               & (drift_full > -max_dur_ext) & (drift_full < max_dur_ext);
	// Drift fits DLY_W whenever it is used (|drift| < 2^24).
	assign drift = drift_full[DLY_W-1:0];

	// ---------------------------------------------------------------
	// Pacing state
	// ---------------------------------------------------------------
	logic [TIME_W-1:0] last_pts_q;
	logic              last_known_q;
	logic [TIME_W-1:0] pace_timer_q;

	// ---------------------------------------------------------------
	// Nominal duration: pts step since the last shown frame, falling back
	// to default_duration when unknown, non-positive or implausibly long.
	// The exact difference is enough; saturation never lands in range.
	// ---------------------------------------------------------------
	logic signed [DIFF_W-1:0] step;
	logic                     step_ok;
	logic signed [DLY_W-1:0]  dly_nom;

	assign step = $signed({pts_s1[TIME_W-1], pts_s1})
	            - $signed({last_pts_q[TIME_W-1], last_pts_q});
	assign step_ok = pts_ok_s1 & last_known_q & (step > 0) & (step <= max_dur_ext);
	assign dly_nom = step_ok ? step[DLY_W-1:0]
	                         : $signed({{(DLY_W-CFG_W){1'b0}}, cfg.default_dur});

	// ---------------------------------------------------------------
	// Sync adjustment. Threshold = clamp(delay, min, max), min wins when
	// the bounds cross. Lagging video shortens the delay (floored at 0);
	// leading video either adds the lead (long frames) or doubles.
	// ---------------------------------------------------------------
	logic signed [DLY_W-1:0] min_th;
	logic signed [DLY_W-1:0] max_th;
	logic signed [DLY_W-1:0] dup_th;
	logic signed [DLY_W-1:0] th_hi;
	logic signed [DLY_W-1:0] th;
	logic signed [DLY_W-1:0] lead;
	logic signed [DLY_W-1:0] dly;

	assign min_th = $signed({{(DLY_W-CFG_W){1'b0}}, cfg.min_sync_th});
	assign max_th = $signed({{(DLY_W-CFG_W){1'b0}}, cfg.max_sync_th});
	assign dup_th = $signed({{(DLY_W-CFG_W){1'b0}}, cfg.frame_dup_th});
	assign th_hi  = (dly_nom < max_th) ? dly_nom : max_th;
	assign th     = (th_hi < min_th) ? min_th : th_hi;
	assign lead   = dly_nom + drift;

	always_comb begin
		dly = dly_nom;
		if (sync_ok) begin
			if (drift <= -th) begin
				dly = lead[DLY_W-1] ? '0 : lead;
			end else if (drift >= th) begin
				dly = (dly_nom > dup_th) ? lead : (dly_nom <<< 1);
			end
		end
	end

	// ---------------------------------------------------------------
	// Due time = timer + delay (saturating; delay is never negative, so
	// only the top can overflow). remain = due - now, exact in DIFF_W.
	// ---------------------------------------------------------------
	logic [DIFF_W-1:0]        due_full;
	logic [TIME_W-1:0]        due;
	logic signed [DIFF_W-1:0] remain;
	logic signed [DIFF_W-1:0] refresh_ext;
	logic signed [DIFF_W-1:0] neg_max_th;
	logic                     show;
	logic                     resync;
	logic [CFG_W-1:0]         wait_val;

	assign due_full = {pace_timer_q[TIME_W-1], pace_timer_q}
	                + {{(DIFF_W-DLY_W){1'b0}}, dly};
	assign due = (due_full[DIFF_W-1:DIFF_W-2] == 2'b01)
	           ? {1'b0, {(TIME_W-1){1'b1}}} : due_full[TIME_W-1:0];
	assign remain = $signed({due[TIME_W-1], due}) - $signed({now_s1[TIME_W-1], now_s1});

	assign refresh_ext = $signed({{(DIFF_W-CFG_W){1'b0}}, cfg.refresh_time});
	assign neg_max_th  = -$signed({{(DIFF_W-CFG_W){1'b0}}, cfg.max_sync_th});

	assign show     = (remain <= 0);
	assign wait_val = (remain < refresh_ext) ? remain[CFG_W-1:0] : cfg.refresh_time;
	// now - due > max_th, i.e. the timer fell too far behind: snap to now.
	assign resync   = (|dly) & (remain < neg_max_th);

	// ---------------------------------------------------------------
	// Result register and state update
	// ---------------------------------------------------------------
	logic              show_q;
	logic [CFG_W-1:0]  wait_q;
	logic [TGT_W-1:0]  delay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			last_pts_q     <= '0;
			last_known_q   <= 1'b0;
			pace_timer_q   <= '0;
		end else begin
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (advance && show) begin
				last_pts_q   <= pts_ok_s1 ? pts_s1 : '0;
				last_known_q <= pts_ok_s1;
				pace_timer_q <= resync ? now_s1 : due;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			show_q  <= show;
			wait_q  <= show ? '0 : wait_val;
			delay_q <= dly[TGT_W-1:0];
		end
	end

	assign result_valid = result_valid_q;
	assign show_frame   = show_q;
	assign retry_wait   = wait_q;
	assign target_delay = delay_q;

endmodule

### hw/rtl/afp_regs.sv
module afp_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [afp_pkg::ADDR_W-1:0]    paddr,
	input  logic [afp_pkg::APB_W-1:0]     pwdata,
	output logic [afp_pkg::APB_W-1:0]     prdata,
	output logic                          pready,
	output afp_pkg::cfg_t                 cfg
);
	import afp_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;
	logic [CFG_W-1:0] wval;
	logic [CFG_W-1:0] rval;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign wval   = pwdata[CFG_W-1:0];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_sync_th   <= RST_MIN_SYNC_TH;
			cfg_q.max_sync_th   <= RST_MAX_SYNC_TH;
			cfg_q.frame_dup_th  <= RST_FRAME_DUP_TH;
			cfg_q.max_frame_dur <= RST_MAX_FRAME_DUR;
			cfg_q.refresh_time  <= RST_REFRESH_TIME;
			cfg_q.default_dur   <= RST_DEFAULT_DUR;
		end else if (wr_en) begin
			case (idx)
				REG_MIN_SYNC_TH:   cfg_q.min_sync_th   <= wval;
				REG_MAX_SYNC_TH:   cfg_q.max_sync_th   <= wval;
				REG_FRAME_DUP_TH:  cfg_q.frame_dup_th  <= wval;
				REG_MAX_FRAME_DUR: cfg_q.max_frame_dur <= wval;
				REG_REFRESH_TIME:  cfg_q.refresh_time  <= wval;
				REG_DEFAULT_DUR:   cfg_q.default_dur   <= wval;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MIN_SYNC_TH:   rval = cfg_q.min_sync_th;
			REG_MAX_SYNC_TH:   rval = cfg_q.max_sync_th;
			REG_FRAME_DUP_TH:  rval = cfg_q.frame_dup_th;
			REG_MAX_FRAME_DUR: rval = cfg_q.max_frame_dur;
			REG_REFRESH_TIME:  rval = cfg_q.refresh_time;
			REG_DEFAULT_DUR:   rval = cfg_q.default_dur;
			default:           rval = '0;
		endcase
	end

	assign prdata = {{(APB_W-CFG_W){1'b0}}, rval};

endmodule

### test/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import afp_pkg::*;

	// Signed time range at TIME_W bits; all time arithmetic saturates here.
	localparam longint T_MAX = (longint'(1) <<< (TIME_W - 1)) - 1;
	localparam longint T_MIN = -T_MAX - 1;
	// Longest run of cycles with no transaction on either side before giving up.
	// Worst case is the long receiver hold plus a drain and a full register
	// reprogram, well under this.
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 250;
	localparam int N_PHASES = 8;
	localparam int PHASE_FRAMES = 125;

	// One frame transaction as seen on the input ports.
	typedef struct packed {
		logic [TIME_W-1:0] pts;
		logic              pts_ok;
		logic [TIME_W-1:0] vclk;
		logic              vclk_ok;
		logic [TIME_W-1:0] mclk;
		logic              mclk_ok;
		logic [TIME_W-1:0] now_us;
	} frame_t;

	// One pacing decision as seen on the result ports.
	typedef struct packed {
		logic             show;
		logic [CFG_W-1:0] wait_us;
		logic [TGT_W-1:0] delay;
	} pace_res_t;

	function automatic longint clamp_time(longint v);
		if (v > T_MAX)
			return T_MAX;
		if (v < T_MIN)
			return T_MIN;
		return v;
	endfunction

	// Tracks the pacing state and register copy, predicts the decision for
	// every accepted frame and checks results against them in order.
	class pace_checker;
		cfg_t      cfg;
		longint    last_pts;
		bit        last_known;
		longint    pace_timer;
		pace_res_t expected_paces[$];
		int        errors;
		int        n_frames;
		int        n_shown;
		int        n_waits;

		function new();
			cfg.min_sync_th   = RST_MIN_SYNC_TH;
			cfg.max_sync_th   = RST_MAX_SYNC_TH;
			cfg.frame_dup_th  = RST_FRAME_DUP_TH;
			cfg.max_frame_dur = RST_MAX_FRAME_DUR;
			cfg.refresh_time  = RST_REFRESH_TIME;
			cfg.default_dur   = RST_DEFAULT_DUR;
			last_pts = 0;
			last_known = 0;
			pace_timer = 0;
			errors = 0;
			n_frames = 0;
			n_shown = 0;
			n_waits = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_MIN_SYNC_TH:   cfg.min_sync_th = v;
				REG_MAX_SYNC_TH:   cfg.max_sync_th = v;
				REG_FRAME_DUP_TH:  cfg.frame_dup_th = v;
				REG_MAX_FRAME_DUR: cfg.max_frame_dur = v;
				REG_REFRESH_TIME:  cfg.refresh_time = v;
				REG_DEFAULT_DUR:   cfg.default_dur = v;
				default: ;
			endcase
		endfunction

		function void note_frame(frame_t f);
			longint    min_th, max_th, dup_th, max_dur, refresh;
			longint    pts, vclk, mclk, now_us;
			longint    delay, d, diff, th, actual, w;
			pace_res_t r;
			min_th  = longint'(cfg.min_sync_th);
			max_th  = longint'(cfg.max_sync_th);
			dup_th  = longint'(cfg.frame_dup_th);
			max_dur = longint'(cfg.max_frame_dur);
			refresh = longint'(cfg.refresh_time);
			pts     = $signed(f.pts);
			vclk    = $signed(f.vclk);
			mclk    = $signed(f.mclk);
			now_us  = $signed(f.now_us);
			n_frames++;

			// nominal duration from the last shown pts, else the default
			delay = longint'(cfg.default_dur);
			if (f.pts_ok && last_known) begin
				d = clamp_time(pts - last_pts);
				if (d > 0 && d <= max_dur)
					delay = d;
			end

			// sync against the master clock: shorten, extend by the lead, or double
			if (f.mclk_ok && mclk > 0 && f.vclk_ok) begin
				diff = clamp_time(vclk - mclk);
				th = (delay < max_th) ? delay : max_th;
				if (th < min_th)
					th = min_th;
				if (diff > -max_dur && diff < max_dur) begin
					if (diff <= -th) begin
						delay = delay + diff;
						if (delay < 0)
							delay = 0;
					end else if (diff >= th && delay > dup_th) begin
						delay = delay + diff;
					end else if (diff >= th) begin
						delay = 2 * delay;
					end
				end
			end

			r.delay = delay[TGT_W-1:0];
			actual = clamp_time(clamp_time(pace_timer + delay) - now_us);
			if (actual > 0) begin
				// too early: report a wait, pacing state untouched
				w = (actual < refresh) ? actual : refresh;
				r.show = 1'b0;
				r.wait_us = w[CFG_W-1:0];
			end else begin
				last_pts = f.pts_ok ? pts : 0;
				last_known = f.pts_ok;
				pace_timer = clamp_time(pace_timer + delay);
				// drifted too far behind: snap the timer to now
				if (delay > 0 && clamp_time(now_us - pace_timer) > max_th)
					pace_timer = now_us;
				r.show = 1'b1;
				r.wait_us = '0;
			end
			expected_paces.push_back(r);
		endfunction

		function void check_result(time t, logic show, logic [CFG_W-1:0] wait_us,
				logic [TGT_W-1:0] delay);
			pace_res_t want;
			if (expected_paces.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual show=%0d wait=%0d delay=%0d",
					t, show, wait_us, delay);
				return;
			end
			want = expected_paces.pop_front();
			if (want.show)
				n_shown++;
			else
				n_waits++;
			if (show !== want.show) begin
				errors++;
				$display("%0t: show_frame mismatch, expected %0d, actual %0d", t, want.show, show);
			end
			if (wait_us !== want.wait_us) begin
				errors++;
				$display("%0t: retry_wait mismatch, expected %0d, actual %0d",
					t, want.wait_us, wait_us);
			end
			if (delay !== want.delay) begin
				errors++;
				$display("%0t: target_delay mismatch, expected %0d, actual %0d",
					t, want.delay, delay);
			end
		endfunction

		function int pending();
			return expected_paces.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               frame_valid = 1'b0;
	logic               frame_stall;
	logic [TIME_W-1:0]  frame_pts = '0;
	logic               frame_pts_valid = 1'b0;
	logic [TIME_W-1:0]  video_clock = '0;
	logic               video_clock_valid = 1'b0;
	logic [TIME_W-1:0]  master_clock = '0;
	logic               master_clock_valid = 1'b0;
	logic [TIME_W-1:0]  now_time = '0;

	logic               result_valid;
	logic               result_stall = 1'b0;
	logic               show_frame;
	logic [CFG_W-1:0]   retry_wait;
	logic [TGT_W-1:0]   target_delay;

	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [APB_W-1:0]   pwdata = '0;
	logic [APB_W-1:0]   prdata;
	logic               pready;

	av_sync_frame_pacer dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.frame_valid        (frame_valid),
		.frame_stall        (frame_stall),
		.frame_pts          (frame_pts),
		.frame_pts_valid    (frame_pts_valid),
		.video_clock        (video_clock),
		.video_clock_valid  (video_clock_valid),
		.master_clock       (master_clock),
		.master_clock_valid (master_clock_valid),
		.now_time           (now_time),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.show_frame         (show_frame),
		.retry_wait         (retry_wait),
		.target_delay       (target_delay),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.prdata             (prdata),
		.pready             (pready)
	);

	always #5 clk = ~clk;

	pace_checker pacer_sb = new();

	// Knobs shared by the stimulus and the result-side stall process.
	bit     tx_idle = 1'b0;
	bit     rx_idle = 1'b0;
	bit     hold_req = 1'b0;
	int     hold_left = 0;
	int     burst_left = 0;
	int     quiet_cycles = 0;
	int     n_settings = 0;
	longint cur_pts;

	// ------------------------------------------------------------------
	// Random helpers
	// ------------------------------------------------------------------
	function automatic longint urng(longint lo, longint hi);
		return lo + longint'($urandom_range(32'(hi - lo), 0));
	endfunction

	function automatic longint srand(longint n);
		return urng(-n, n);
	endfunction

	function automatic logic [TIME_W-1:0] rand_time();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[TIME_W-1:0];
	endfunction

	function automatic logic [TIME_W-1:0] corner_time();
		case ($urandom_range(0, 5))
			0: return T_MAX[TIME_W-1:0];
			1: return T_MIN[TIME_W-1:0];
			2: return '0;
			3: return '1;
			4: return {{(TIME_W-1){1'b0}}, 1'b1};
			default: return rand_time();
		endcase
	endfunction

	function automatic frame_t mk(longint pts, bit pv, longint vclk, bit vv,
			longint mclk, bit mv, longint now_us);
		frame_t f;
		f.pts = pts[TIME_W-1:0];
		f.pts_ok = pv;
		f.vclk = vclk[TIME_W-1:0];
		f.vclk_ok = vv;
		f.mclk = mclk[TIME_W-1:0];
		f.mclk_ok = mv;
		f.now_us = now_us[TIME_W-1:0];
		return f;
	endfunction

	// Mostly a plausible playback stream: pts advancing by a frame period,
	// master tracking pts, video clock off by a lead or lag that lands near
	// the thresholds, and "now" placed around the predicted frame timer so
	// that both waits and shows occur. The rest is raw noise and corners.
	function automatic frame_t rand_frame();
		frame_t f;
		longint step, diff, mclk, now_us;
		int     kind;
		kind = $urandom_range(0, 19);
		if (kind == 0) begin
			f.pts = rand_time();
			f.vclk = rand_time();
			f.mclk = rand_time();
			f.now_us = rand_time();
			f.pts_ok = ($urandom_range(0, 1) == 1);
			f.vclk_ok = ($urandom_range(0, 1) == 1);
			f.mclk_ok = ($urandom_range(0, 1) == 1);
			return f;
		end
		if (kind == 1) begin
			f.pts = corner_time();
			f.vclk = corner_time();
			f.mclk = corner_time();
			f.now_us = corner_time();
			f.pts_ok = ($urandom_range(0, 3) != 0);
			f.vclk_ok = ($urandom_range(0, 3) != 0);
			f.mclk_ok = ($urandom_range(0, 3) != 0);
			return f;
		end

		// a retry of the same frame keeps the pts
		if ($urandom_range(0, 2) != 0) begin
			case ($urandom_range(0, 9))
				0: step = 0;
				1: step = -urng(1, 200000);
				2: step = urng(1, 33554432);
				3: step = urng(100000, 300000);
				4: step = longint'(pacer_sb.cfg.max_frame_dur) + srand(1);
				default: step = urng(30000, 50000);
			endcase
			cur_pts = cur_pts + step;
		end

		case ($urandom_range(0, 6))
			0: diff = srand(150000);
			1: diff = ($urandom_range(0, 1) ? 1 : -1) *
				(longint'(pacer_sb.cfg.min_sync_th) + srand(2));
			2: diff = ($urandom_range(0, 1) ? 1 : -1) *
				(longint'(pacer_sb.cfg.max_sync_th) + srand(2));
			3: diff = ($urandom_range(0, 1) ? 1 : -1) *
				(longint'(pacer_sb.cfg.max_frame_dur) + srand(2));
			4: diff = 0;
			5: diff = srand(1073741824);
			default: diff = srand(60000);
		endcase

		mclk = cur_pts + srand(20000);
		if ($urandom_range(0, 15) == 0)
			mclk = -urng(0, 1000);

		if ($urandom_range(0, 7) == 0)
			now_us = pacer_sb.pace_timer + urng(0, 1073741824);
		else
			now_us = pacer_sb.pace_timer + urng(-150000, 400000);

		return mk(cur_pts, ($urandom_range(0, 11) != 0), mclk + diff,
			($urandom_range(0, 11) != 0), mclk, ($urandom_range(0, 11) != 0), now_us);
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Offer a frame and hold it until the block takes it.
	task automatic send_frame(frame_t f);
		frame_valid <= 1'b1;
		frame_pts <= f.pts;
		frame_pts_valid <= f.pts_ok;
		video_clock <= f.vclk;
		video_clock_valid <= f.vclk_ok;
		master_clock <= f.mclk;
		master_clock_valid <= f.mclk_ok;
		now_time <= f.now_us;
		@(posedge clk);
		while (frame_stall)
			@(posedge clk);
	endtask

	task automatic idle_frames(int n);
		frame_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Stop offering and wait until every predicted result has been checked.
	// The first edge lets the monitor log the last accepted frame; the tail
	// covers the two-stage pipe.
	task automatic drain_results();
		frame_valid <= 1'b0;
		@(posedge clk);
		while (pacer_sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the
	// edge where pready is seen high.
	task automatic reg_write(reg_idx_t idx, logic [CFG_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {{(APB_W-CFG_W){1'b0}}, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		pacer_sb.write_reg(idx, v);
	endtask

	task automatic program_regs(cfg_t c);
		reg_write(REG_MIN_SYNC_TH, c.min_sync_th);
		reg_write(REG_MAX_SYNC_TH, c.max_sync_th);
		reg_write(REG_FRAME_DUP_TH, c.frame_dup_th);
		reg_write(REG_MAX_FRAME_DUR, c.max_frame_dur);
		reg_write(REG_REFRESH_TIME, c.refresh_time);
		reg_write(REG_DEFAULT_DUR, c.default_dur);
		n_settings++;
	endtask

	// ------------------------------------------------------------------
	// Result-side backpressure: random bursts, plus a long hold on request
	// so the pipe fills and the block stalls its input.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_req || hold_left > 0) begin
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			hold_left--;
			result_stall <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left--;
			result_stall <= 1'b1;
		end else if (rx_idle && $urandom_range(0, 5) == 0) begin
			burst_left = int'(urng(0, 17));
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: log accepted frames, check accepted results, and watch for
	// a hang (no transaction on either side for too long).
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (frame_valid && !frame_stall)
				pacer_sb.note_frame(mk($signed(frame_pts), frame_pts_valid,
					$signed(video_clock), video_clock_valid,
					$signed(master_clock), master_clock_valid, $signed(now_time)));
			if (result_valid && !result_stall)
				pacer_sb.check_result($time, show_frame, retry_wait, target_delay);
			if ((frame_valid && !frame_stall) || (result_valid && !result_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d results outstanding",
					$time, IDLE_LIMIT, pacer_sb.pending());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		cfg_t c;
		int   ph;
		int   n;

		cur_pts = urng(1000000, 2000000000);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, at reset register values (thresholds 40 ms / 100 ms,
		// default duration 40 ms, refresh 10 ms).
		// no frame shown yet: default duration, too early -> wait
		send_frame(mk(1000000, 1, 0, 0, 0, 0, 0));
		// same frame once due -> show
		send_frame(mk(1000000, 1, 0, 0, 0, 0, 40000));
		// in sync, no adjustment
		send_frame(mk(1040000, 1, 1040000, 1, 1040000, 1, 80000));
		// video far behind: shortened past zero, clamps at zero
		send_frame(mk(1080000, 1, 1030000, 1, 1080000, 1, 200000));
		// video behind: shortened; timer then snaps forward on drift
		send_frame(mk(1200000, 1, 1090000, 1, 1200000, 1, 300000));
		// video ahead, short delay: doubled
		send_frame(mk(1240000, 1, 1290000, 1, 1240000, 1, 400000));
		// video ahead, long delay: lead added; first early, then retried
		send_frame(mk(1390000, 1, 1510000, 1, 1390000, 1, 600000));
		send_frame(mk(1390000, 1, 1510000, 1, 1390000, 1, 700000));
		// video lead beyond the plausible range: left alone
		send_frame(mk(1430000, 1, 21430000, 1, 1430000, 1, 700000));
		// master zero, then negative: no sync
		send_frame(mk(1470000, 1, 2000000, 1, 0, 1, 800000));
		send_frame(mk(1510000, 1, 2000000, 1, -5, 1, 900000));
		// invalid video clock, then invalid master clock
		send_frame(mk(1550000, 1, 5000000, 0, 1550000, 1, 1000000));
		send_frame(mk(1590000, 1, 5000000, 1, 1590000, 0, 1100000));
		// invalid pts shown, so the next valid one falls back to the default
		send_frame(mk(0, 0, 1630000, 1, 1630000, 1, 1200000));
		send_frame(mk(1700000, 1, 1700000, 1, 1700000, 1, 1300000));
		// zero step, backwards step, step beyond max duration
		send_frame(mk(1700000, 1, 1700000, 1, 1700000, 1, 1400000));
		send_frame(mk(1600000, 1, 1600000, 1, 1600000, 1, 1500000));
		send_frame(mk(21700000, 1, 21700000, 1, 21700000, 1, 1600000));
		// saturation: timer pushed to the top of the range, then differences
		// against the bottom of the range
		send_frame(mk(T_MAX, 1, T_MAX, 1, T_MAX, 1, T_MAX));
		send_frame(mk(T_MIN, 1, T_MIN, 1, 1, 1, T_MIN));
		send_frame(mk(T_MIN, 1, T_MIN, 1, 1, 1, T_MAX));
		send_frame(mk(T_MAX, 1, T_MIN, 1, T_MAX, 1, T_MIN));
		// nothing valid at all
		send_frame(mk(0, 0, 0, 0, 0, 0, 0));
		drain_results();

		// Random phases, each with its own register setting.
		for (ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: begin
					c.min_sync_th = RST_MIN_SYNC_TH;
					c.max_sync_th = RST_MAX_SYNC_TH;
					c.frame_dup_th = RST_FRAME_DUP_TH;
					c.max_frame_dur = RST_MAX_FRAME_DUR;
					c.refresh_time = RST_REFRESH_TIME;
					c.default_dur = RST_DEFAULT_DUR;
				end
				1: c = '0;
				2: c = '1;
				default: begin
					c.min_sync_th = CFG_W'(urng(0, 80000));
					c.max_sync_th = CFG_W'(urng(0, 200000));
					c.frame_dup_th = CFG_W'(urng(0, 200000));
					c.max_frame_dur = CFG_W'(urng(1000, 16777215));
					c.refresh_time = CFG_W'(urng(1, 40000));
					c.default_dur = CFG_W'(urng(0, 80000));
				end
			endcase
			// thresholds crossed: min above max
			if (ph == 3) begin
				c.min_sync_th = CFG_W'(urng(50000, 200000));
				c.max_sync_th = CFG_W'(urng(0, 40000));
			end
			// zero refresh: early frames report a zero wait
			if (ph == 4)
				c.refresh_time = '0;
			program_regs(c);

			for (n = 0; n < PHASE_FRAMES; n++) begin
				// re-pick idling every few dozen frames; the last phase runs flat out
				if (n % 25 == 0) begin
					tx_idle = (ph != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
					rx_idle = (ph != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
				end
				// sender pauses until everything in flight has come back
				if (ph == 3 && n == 60)
					drain_results();
				// receiver holds off for a long stretch while frames keep coming
				if (ph == 5 && n == 40)
					hold_req = 1'b1;
				if (tx_idle && $urandom_range(0, 5) == 0)
					idle_frames(int'(urng(1, 18)));
				send_frame(rand_frame());
			end
			drain_results();
		end

		repeat (8) @(posedge clk);
		$display("Checked %0d frames across %0d register settings plus reset values:",
			pacer_sb.n_frames, n_settings);
		$display("  %0d shown, %0d told to wait, %0d mismatches",
			pacer_sb.n_shown, pacer_sb.n_waits, pacer_sb.errors);
		if (pacer_sb.errors == 0 && pacer_sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
